// ===== sv/pfr_pkg.sv =====
// Shared constants for the two-objective Pareto front ranking unit.
`timescale 1ns / 1ps
`default_nettype none
package pfr_pkg;
   localparam int MAX_POINTS_DEF = 64;
   localparam int OBJ_WIDTH_DEF  = 32;
   localparam int FIELD_W        = 32;
   localparam int FRONT_W        = 6;
endpackage
`default_nettype wire

// ===== sv/pareto_front_rank_two_objective_unit.sv =====
// Sequence: a loaded word is written to the point memory when accepted. After the set_end
//   word the unit ranks the stored points, sweeps them into fronts, then emits them front
//   by front, holding on output stalls. Each phase steps through the point, sorted and front
//   memories one read at a time.
// Throughput: one set at a time; req_ready is high only while loading.
// Reset: synchronous, active high; clears the point and front counts, drop flag, state and rsp_valid.
`timescale 1ns / 1ps
`default_nettype none
module pareto_front_rank_two_objective_unit
   import pfr_pkg::*;
#(
   parameter int MAX_POINTS = MAX_POINTS_DEF,
   parameter int OBJ_WIDTH  = OBJ_WIDTH_DEF
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [FIELD_W-1:0] req_obj_one,
   input  wire logic [FIELD_W-1:0] req_obj_two,
   input  wire logic               req_set_end,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [FIELD_W-1:0]      rsp_out_one,
   output logic [FIELD_W-1:0]      rsp_out_two,
   output logic [FRONT_W-1:0]      rsp_front_index,
   output logic                    rsp_run_end,
   output logic                    rsp_overflowed
);
   localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
   localparam int CW    = $clog2(MAX_POINTS + 1);
   localparam int DEPTH = 1 << AW;
   // objectives are held at the narrower of the port width and OBJ_WIDTH
   localparam int SW    = (OBJ_WIDTH < FIELD_W) ? OBJ_WIDTH : FIELD_W;

   typedef enum logic [3:0] {
      S_LOAD, S_RGET, S_RCUR, S_RSCAN, S_SGET, S_SCUR, S_SSCAN, S_EGET, S_ESCAN
   } state_type;

   state_type         state_ff;
   logic [CW-1:0]     count_ff, fc_ff, emit_ff;
   logic              drop_ff;
   logic [AW-1:0]     i_ff, j_ff, rank_ff, f_ff;
   logic [SW-1:0]     cur1_ff, cur2_ff;
   logic              rsp_valid_ff, run_end_ff, ovf_ff;
   logic [FIELD_W-1:0] one_ff, two_ff;
   logic [FRONT_W-1:0] front_ff;

   // point memory: words in arrival order
   logic [SW-1:0] p1_mem [DEPTH];
   logic [SW-1:0] p2_mem [DEPTH];
   logic [SW-1:0] p_rd1, p_rd2;
   logic [AW-1:0] pa;
   logic          p_we;
   // sorted memory: points by (first, second) plus their front
   logic [SW-1:0] s1_mem [DEPTH];
   logic [SW-1:0] s2_mem [DEPTH];
   logic [AW-1:0] sf_mem [DEPTH];
   logic [SW-1:0] s_rd1, s_rd2;
   logic [AW-1:0] sf_rd, sa, sf_wd;
   logic          s_we, sf_we;
   // front memory: best second objective and its first objective
   logic [SW-1:0] fb2_mem [DEPTH];
   logic [SW-1:0] fb1_mem [DEPTH];
   logic [SW-1:0] f_rd1, f_rd2, f_wd1, f_wd2;
   logic [AW-1:0] fa, f_wa;
   logic          f_we;

   logic          last_j, last_i, last_f, rank_less, rej, match, proceed, out_free, fc_zero;
   logic          emit_load;
   logic [AW-1:0] rank_fin, i_next, j_next;

   always_ff @(posedge clock) begin
      if (p_we) begin
         p1_mem[count_ff[AW-1:0]] <= req_obj_one[SW-1:0];
         p2_mem[count_ff[AW-1:0]] <= req_obj_two[SW-1:0];
      end
      p_rd1 <= p1_mem[pa];
      p_rd2 <= p2_mem[pa];
   end

   always_ff @(posedge clock) begin
      if (s_we) begin
         s1_mem[rank_fin] <= cur1_ff;
         s2_mem[rank_fin] <= cur2_ff;
      end
      if (sf_we) begin
         sf_mem[i_ff] <= sf_wd;
      end
      s_rd1 <= s1_mem[sa];
      s_rd2 <= s2_mem[sa];
      sf_rd <= sf_mem[sa];
   end

   always_ff @(posedge clock) begin
      if (f_we) begin
         fb1_mem[f_wa] <= f_wd1;
         fb2_mem[f_wa] <= f_wd2;
      end
      f_rd1 <= fb1_mem[fa];
      f_rd2 <= fb2_mem[fa];
   end

   assign i_next    = i_ff + AW'(1);
   assign j_next    = j_ff + AW'(1);
   assign last_j    = (CW'(j_ff) == count_ff - CW'(1));
   assign last_i    = (CW'(i_ff) == count_ff - CW'(1));
   assign last_f    = (CW'(j_ff) + CW'(1) == fc_ff);
   assign fc_zero   = (fc_ff == '0);
   // stable rank: earlier index wins a tie on the full key
   assign rank_less = ({p_rd1, p_rd2} < {cur1_ff, cur2_ff}) ||
                      (({p_rd1, p_rd2} == {cur1_ff, cur2_ff}) && (j_ff < i_ff));
   assign rank_fin  = rank_ff + AW'(rank_less);
   // front rejects a point its best strictly dominates; a duplicate is accepted
   assign rej       = (f_rd2 < cur2_ff) || ((f_rd2 == cur2_ff) && (f_rd1 < cur1_ff));
   assign match     = (sf_rd == f_ff);
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign proceed   = !match || out_free;
   // a matching point goes into the output register this cycle
   assign emit_load = (state_ff == S_ESCAN) && proceed && match;

   always_comb begin
      pa    = '0;
      sa    = '0;
      fa    = '0;
      p_we  = 1'b0;
      s_we  = 1'b0;
      sf_we = 1'b0;
      sf_wd = '0;
      f_we  = 1'b0;
      f_wa  = '0;
      f_wd1 = cur1_ff;
      f_wd2 = cur2_ff;
      case (state_ff)
         S_LOAD: begin
            p_we = req_valid && (count_ff < CW'(MAX_POINTS));
         end
         S_RGET: begin
            pa = i_ff;
         end
         S_RSCAN: begin
            pa   = last_j ? i_next : j_next;
            s_we = last_j;
         end
         S_SGET: begin
            sa = i_ff;
         end
         S_SCUR: begin
            if (fc_zero) begin
               // first point of the sweep opens front 0
               f_we  = 1'b1;
               f_wd1 = s_rd1;
               f_wd2 = s_rd2;
               sf_we = 1'b1;
               sa    = i_next;
            end
         end
         S_SSCAN: begin
            fa = j_next;
            sa = i_next;
            if (!rej) begin
               f_we  = (cur2_ff < f_rd2);
               f_wa  = j_ff;
               sf_we = 1'b1;
               sf_wd = j_ff;
            end else if (last_f) begin
               f_we  = 1'b1;
               f_wa  = fc_ff[AW-1:0];
               sf_we = 1'b1;
               sf_wd = fc_ff[AW-1:0];
            end
         end
         S_ESCAN: begin
            if (!proceed) begin
               sa = j_ff;
            end else if (!last_j) begin
               sa = j_next;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         count_ff     <= '0;
         fc_ff        <= '0;
         drop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (emit_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_LOAD: begin
               if (req_valid) begin
                  if (count_ff < CW'(MAX_POINTS)) begin
                     count_ff <= count_ff + CW'(1);
                  end else begin
                     drop_ff <= 1'b1;
                  end
                  if (req_set_end) begin
                     i_ff     <= '0;
                     state_ff <= S_RGET;
                  end
               end
            end
            S_RGET: begin
               state_ff <= S_RCUR;
            end
            S_RCUR: begin
               cur1_ff  <= p_rd1;
               cur2_ff  <= p_rd2;
               rank_ff  <= '0;
               j_ff     <= '0;
               state_ff <= S_RSCAN;
            end
            S_RSCAN: begin
               rank_ff <= rank_fin;
               j_ff    <= j_next;
               if (last_j) begin
                  if (last_i) begin
                     i_ff     <= '0;
                     fc_ff    <= '0;
                     state_ff <= S_SGET;
                  end else begin
                     i_ff     <= i_next;
                     state_ff <= S_RCUR;
                  end
               end
            end
            S_SGET: begin
               state_ff <= S_SCUR;
            end
            S_SCUR: begin
               if (fc_zero) begin
                  fc_ff <= CW'(1);
                  if (last_i) begin
                     f_ff     <= '0;
                     emit_ff  <= '0;
                     state_ff <= S_EGET;
                  end else begin
                     i_ff <= i_next;
                  end
               end else begin
                  cur1_ff  <= s_rd1;
                  cur2_ff  <= s_rd2;
                  j_ff     <= '0;
                  state_ff <= S_SSCAN;
               end
            end
            S_SSCAN: begin
               if (!rej || last_f) begin
                  if (rej) begin
                     fc_ff <= fc_ff + CW'(1);
                  end
                  if (last_i) begin
                     f_ff     <= '0;
                     emit_ff  <= '0;
                     state_ff <= S_EGET;
                  end else begin
                     i_ff     <= i_next;
                     state_ff <= S_SCUR;
                  end
               end else begin
                  j_ff <= j_next;
               end
            end
            S_EGET: begin
               j_ff     <= '0;
               state_ff <= S_ESCAN;
            end
            S_ESCAN: begin
               if (proceed) begin
                  if (match) begin
                     one_ff       <= FIELD_W'(s_rd1);
                     two_ff       <= FIELD_W'(s_rd2);
                     front_ff     <= FRONT_W'(f_ff);
                     run_end_ff   <= (emit_ff + CW'(1) == count_ff);
                     ovf_ff       <= drop_ff;
                     emit_ff      <= emit_ff + CW'(1);
                  end
                  if (last_j) begin
                     j_ff <= '0;
                     if (CW'(f_ff) + CW'(1) == fc_ff) begin
                        count_ff <= '0;
                        fc_ff    <= '0;
                        drop_ff  <= 1'b0;
                        state_ff <= S_LOAD;
                     end else begin
                        f_ff <= f_ff + AW'(1);
                     end
                  end else begin
                     j_ff <= j_next;
                  end
               end
            end
            default: begin
               state_ff <= S_LOAD;
            end
         endcase
      end
   end

   assign req_ready       = (state_ff == S_LOAD);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_one     = one_ff;
   assign rsp_out_two     = two_ff;
   assign rsp_front_index = front_ff;
   assign rsp_run_end     = run_end_ff;
   assign rsp_overflowed  = ovf_ff;

   // stored count never passes capacity
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_POINTS))
      else $error("point count beyond capacity");
   // every front holds at least one point
   a_front_le_points: assert property (@(posedge clock) disable iff (reset)
      fc_ff <= count_ff)
      else $error("more fronts than points");
   // emission never runs past the stored set
   a_emit_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ESCAN) |-> (emit_ff <= count_ff))
      else $error("emitted more words than stored points");
endmodule
`default_nettype wire

// ===== sim/tb_pareto_front_rank_two_objective_unit.sv =====
// Self-checking testbench for the two-objective Pareto front ranking unit.
`timescale 1ns / 1ps
`default_nettype none
module tb_pareto_front_rank_two_objective_unit;
   import pfr_pkg::*;

   localparam int CAPACITY = MAX_POINTS_DEF;

   typedef struct packed {
      logic [FIELD_W-1:0] one;
      logic [FIELD_W-1:0] two;
   } point_type;

   typedef struct packed {
      logic [FIELD_W-1:0] one;
      logic [FIELD_W-1:0] two;
      logic [FRONT_W-1:0] front;
      logic               run_end;
      logic               overflowed;
   } ranked_word_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [FIELD_W-1:0] req_obj_one = '0;
   logic [FIELD_W-1:0] req_obj_two = '0;
   logic               req_set_end = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic [FIELD_W-1:0] rsp_out_one;
   logic [FIELD_W-1:0] rsp_out_two;
   logic [FRONT_W-1:0] rsp_front_index;
   logic               rsp_run_end;
   logic               rsp_overflowed;

   // Mirror of the block's point store for the set being loaded.
   point_type       loaded_points[$];
   logic            set_dropped = 1'b0;
   // Ranked words still owed by the block, oldest first.
   ranked_word_type ranked_pending[$];

   int error_count = 0;
   int gap_max     = 0;   // sender idle gap drawn per word, from 0 up to gap_max
   int stall_max   = 0;   // receiver stall drawn per word, from 0 up to stall_max
   int hold_cycles = 0;   // one-shot long receiver hold-off

   pareto_front_rank_two_objective_unit dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Sort the loaded set, sweep it into fronts, and queue the emitted words.
   task automatic rank_loaded_set();
      point_type          sorted[$];
      point_type          p;
      logic [FIELD_W-1:0] best_two[CAPACITY];
      logic [FIELD_W-1:0] best_one[CAPACITY];
      int                 front_of[CAPACITY];
      int                 fronts;
      int                 j;
      int                 pos;
      int                 n;
      int                 k;
      ranked_word_type    w;
      sorted = loaded_points;
      n = sorted.size();
      // stable insertion sort on (one, two) ascending
      for (int i = 1; i < n; i++) begin
         p = sorted[i];
         j = i;
         while (j > 0 && (sorted[j-1].one > p.one ||
                (sorted[j-1].one == p.one && sorted[j-1].two > p.two))) begin
            sorted[j] = sorted[j-1];
            j--;
         end
         sorted[j] = p;
      end
      // first front whose best point does not dominate this one
      fronts = 0;
      for (int i = 0; i < n; i++) begin
         pos = 0;
         while (pos < fronts && (best_two[pos] < sorted[i].two ||
                (best_two[pos] == sorted[i].two && best_one[pos] < sorted[i].one)))
            pos++;
         if (pos == fronts) begin
            best_two[pos] = sorted[i].two;
            best_one[pos] = sorted[i].one;
            fronts++;
         end
         if (sorted[i].two < best_two[pos]) begin
            best_two[pos] = sorted[i].two;
            best_one[pos] = sorted[i].one;
         end
         front_of[i] = pos;
      end
      k = 0;
      for (int f = 0; f < fronts; f++)
         for (int i = 0; i < n; i++)
            if (front_of[i] == f) begin
               w.one        = sorted[i].one;
               w.two        = sorted[i].two;
               w.front      = FRONT_W'(f);
               w.run_end    = (k + 1 == n);
               w.overflowed = set_dropped;
               ranked_pending.insert(ranked_pending.size(), w);
               k++;
            end
      loaded_points.delete();
      set_dropped = 1'b0;
   endtask

   // Offer one word after a random gap; valid stays up across back-to-back words.
   task automatic send_point(input logic [FIELD_W-1:0] one, input logic [FIELD_W-1:0] two,
                             input logic last);
      int gap;
      point_type p;
      gap = (gap_max > 0) ? $urandom_range(gap_max, 0) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_obj_one <= one;
      req_obj_two <= two;
      req_set_end <= last;
      do @(posedge clock); while (!req_ready);
      p.one = one;
      p.two = two;
      if (loaded_points.size() < CAPACITY) loaded_points.insert(loaded_points.size(), p);
      else set_dropped = 1'b1;
      if (last) rank_loaded_set();
   endtask

   // Drop valid and wait until the block has returned everything owed.
   task automatic drain();
      req_valid <= 1'b0;
      while (ranked_pending.size() != 0) @(posedge clock);
   endtask

   // Values biased toward ties so duplicates and equal objectives are common.
   function automatic logic [FIELD_W-1:0] draw_obj(input int mode);
      case (mode)
         0: draw_obj = $urandom_range(7, 0);
         1: draw_obj = $urandom_range(255, 0);
         default: draw_obj = $urandom;
      endcase
   endfunction

   task automatic send_random_set(input int n);
      int mode;
      mode = $urandom_range(2, 0);
      for (int i = 0; i < n; i++)
         send_point(draw_obj(mode), draw_obj(mode), i == n - 1);
   endtask

   // Extremes, exact duplicates, equal second with larger first, single point.
   task automatic test_directed();
      send_point('0, '0, 1'b1);
      send_point('1, '1, 1'b0);
      send_point('0, '1, 1'b0);
      send_point('1, '0, 1'b0);
      send_point('0, '0, 1'b0);
      send_point('0, '0, 1'b1);
      send_point(32'd5, 32'd9, 1'b0);
      send_point(32'd7, 32'd9, 1'b0);
      send_point(32'd5, 32'd9, 1'b0);
      send_point(32'd9, 32'd9, 1'b0);
      send_point(32'd3, 32'd12, 1'b0);
      send_point(32'd8, 32'd2, 1'b1);
      // staircase: each point on its own front
      for (int i = 0; i < 6; i++)
         send_point(32'(i), 32'(i), i == 5);
      drain();
   endtask

   // Capacity full: extra words, the set_end one among them, are dropped.
   task automatic test_overflow();
      gap_max = 2;
      for (int i = 0; i < CAPACITY + 2; i++)
         send_point($urandom_range(15, 0), $urandom_range(15, 0), i == CAPACITY + 1);
      // exactly full set, no drop
      send_random_set(CAPACITY);
      drain();
   endtask

   // Long receiver hold-off while the sender offers the next set; it waits until the unit loads again.
   task automatic test_backpressure();
      gap_max     = 0;
      stall_max   = 0;
      hold_cycles = 3000;
      send_random_set(20);
      send_random_set(10);
      send_random_set(5);
      drain();
   endtask

   task automatic test_random();
      int sent;
      int n;
      sent = 0;
      while (sent < 140) begin
         case ($urandom_range(3, 0))
            0: begin gap_max = 0;  stall_max = 0;  end
            1: begin gap_max = 17; stall_max = 0;  end
            2: begin gap_max = 0;  stall_max = 17; end
            default: begin gap_max = 17; stall_max = 17; end
         endcase
         n = ($urandom_range(15, 0) == 0) ? $urandom_range(CAPACITY, 40)
                                           : $urandom_range(12, 1);
         send_random_set(n);
         sent += n;
         if ($urandom_range(4, 0) == 0) drain();
      end
      drain();
   endtask

   // Receiver: random stall per word, or one long hold-off on request.
   initial begin
      int st;
      forever begin
         if (hold_cycles > 0) begin
            st = hold_cycles;
            hold_cycles = 0;
         end else begin
            st = (stall_max > 0) ? $urandom_range(stall_max, 0) : 0;
         end
         if (st > 0) begin
            rsp_ready <= 1'b0;
            repeat (st) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (rsp_valid !== 1'b1);
      end
   end

   // Compare each accepted word against the oldest owed word.
   always @(posedge clock) begin
      ranked_word_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (ranked_pending.size() == 0) begin
            $display("%0t: unexpected word one=%h two=%h front=%0d", $time,
                     rsp_out_one, rsp_out_two, rsp_front_index);
            error_count++;
         end else begin
            w = ranked_pending.pop_front();
            if (rsp_out_one !== w.one) begin
               $display("%0t: out_one expected %h got %h", $time, w.one, rsp_out_one);
               error_count++;
            end
            if (rsp_out_two !== w.two) begin
               $display("%0t: out_two expected %h got %h", $time, w.two, rsp_out_two);
               error_count++;
            end
            if (rsp_front_index !== w.front) begin
               $display("%0t: front_index expected %0d got %0d", $time, w.front,
                        rsp_front_index);
               error_count++;
            end
            if (rsp_run_end !== w.run_end) begin
               $display("%0t: run_end expected %b got %b", $time, w.run_end, rsp_run_end);
               error_count++;
            end
            if (rsp_overflowed !== w.overflowed) begin
               $display("%0t: overflowed expected %b got %b", $time, w.overflowed,
                        rsp_overflowed);
               error_count++;
            end
         end
      end
   end

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_overflow();
      test_backpressure();
      test_random();
      repeat (200) @(posedge clock);
      if (error_count == 0 && ranked_pending.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      #40ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire
